[rtl/tbl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbl_pkg
// shared types and constants of the token bucket limiter
// ----------------------------------------------------------------------------
package tbl_pkg;

    // field widths
    localparam int TIME_W   = 48;   // request time in ms
    localparam int COST_W   = 16;   // whole tokens
    localparam int CAP_W    = 16;   // capacity in whole tokens
    localparam int RATE_W   = 30;   // milli-tokens per second
    localparam int LEVEL_W  = 36;   // micro-tokens
    localparam int RETRY_W  = 32;
    localparam int CFG_W    = 30;   // widest register
    localparam int CFG_IDX_W = 2;

    // refill product is split into two partial products
    localparam int HALF_W   = LEVEL_W / 2;
    localparam int PP_W     = HALF_W + RATE_W;
    localparam int PROD_W   = LEVEL_W + RATE_W;

    // rate in micro-tokens per second
    localparam int PSEC_W   = RATE_W + 10;
    localparam int DIV_CNT_W = 6;

    localparam logic [19:0] MICRO_PER_TOKEN = 20'd1000000;
    localparam logic [9:0]  MILLI_PER_TOKEN = 10'd1000;
    localparam logic [RETRY_W-1:0] RETRY_ONE = RETRY_W'(1);
    localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 2'd1;

    // job queue
    localparam int JQ_DEPTH = 2;
    localparam int JQ_PTR_W = 1;
    localparam int JQ_CNT_W = 2;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [COST_W-1:0] cost_tokens;
    } t_req;

    typedef struct packed {
        logic               granted;
        logic [RETRY_W-1:0] retry_after_sec;
    } t_res;

    typedef enum logic {
        JOB_FREE,   // zero cost, granted without touching the bucket
        JOB_METER   // goes through refill and check
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [TIME_W-1:0]  now_ms;
        logic [COST_W-1:0]  cost_tokens;
        logic [LEVEL_W-1:0] need_micro;
    } t_job;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     wdata;
    } t_cfg;

endpackage

[rtl/tbl_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbl_front
// classifies incoming requests and turns the cost into micro-tokens
// ----------------------------------------------------------------------------
module tbl_front (
    input  logic          push,
    input  tbl_pkg::t_req i_req,
    input  logic          i_q_full,
    output logic          o_q_push,
    output tbl_pkg::t_job o_job,
    output logic          full
);
    import tbl_pkg::*;

    logic [LEVEL_W-1:0] need_micro;

    assign need_micro = LEVEL_W'(i_req.cost_tokens) * LEVEL_W'(MICRO_PER_TOKEN);

    always_comb begin
        o_job.kind        = (i_req.cost_tokens == '0) ? JOB_FREE : JOB_METER;
        o_job.now_ms      = i_req.now_ms;
        o_job.cost_tokens = i_req.cost_tokens;
        o_job.need_micro  = need_micro;
    end

    assign full     = i_q_full;
    assign o_q_push = push & ~i_q_full;

endmodule

[rtl/tbl_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbl_fifo
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module tbl_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tbl_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output tbl_pkg::t_job o_job,
    output logic          o_empty
);
    import tbl_pkg::*;

    t_job                r_mem [JQ_DEPTH];
    logic [JQ_PTR_W-1:0] r_wr_ptr;
    logic [JQ_PTR_W-1:0] r_rd_ptr;
    logic [JQ_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == JQ_CNT_W'(JQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/tbl_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbl_back
// bucket state, refill, admission check and retry-time divider
// ----------------------------------------------------------------------------
module tbl_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tbl_pkg::t_cfg i_cfg,
    input  tbl_pkg::t_job i_q_job,
    input  logic          i_q_empty,
    output logic          o_q_pop,
    input  logic          pop,
    output logic          empty,
    output tbl_pkg::t_res o_res
);
    import tbl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_SUM,
        S_REFILL,
        S_CHECK,
        S_DIV,
        S_FIN
    } t_state;

    t_state               r_state,     n_state;
    logic [CAP_W-1:0]     r_cap,       n_cap;
    logic [LEVEL_W-1:0]   r_cap_micro, n_cap_micro;
    logic [RATE_W-1:0]    r_rate,      n_rate;
    logic [PSEC_W-1:0]    r_per_sec,   n_per_sec;
    logic [LEVEL_W-1:0]   r_level,     n_level;
    logic [TIME_W-1:0]    r_last,      n_last;
    t_job                 r_job,       n_job;
    logic [TIME_W-1:0]    r_elapsed,   n_elapsed;
    logic [PP_W-1:0]      r_prod_lo,   n_prod_lo;
    logic [PP_W-1:0]      r_prod_hi,   n_prod_hi;
    logic [PROD_W-1:0]    r_prod,      n_prod;
    logic [LEVEL_W-1:0]   r_room,      n_room;
    logic [LEVEL_W-1:0]   r_quo,       n_quo;
    logic [PSEC_W-1:0]    r_rem,       n_rem;
    logic [DIV_CNT_W-1:0] r_cnt,       n_cnt;
    logic                 r_out_valid, n_out_valid;
    t_res                 r_out,       n_out;

    logic [LEVEL_W-1:0] cap_micro_w;
    logic [PSEC_W-1:0]  per_sec_w;
    logic [PSEC_W:0]    rem_sh;
    logic               rem_ge;
    logic [LEVEL_W:0]   ceil_q;
    logic               elapsed_big;

    assign cap_micro_w = LEVEL_W'(i_cfg.wdata[CAP_W-1:0]) * LEVEL_W'(MICRO_PER_TOKEN);
    assign per_sec_w   = PSEC_W'(i_cfg.wdata[RATE_W-1:0]) * PSEC_W'(MILLI_PER_TOKEN);

    // one restoring step per cycle
    assign rem_sh = {r_rem, r_quo[LEVEL_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_per_sec});

    assign ceil_q      = {1'b0, r_quo} + (LEVEL_W + 1)'(r_rem != '0);
    assign elapsed_big = |r_elapsed[TIME_W-1:LEVEL_W];

    assign empty = ~r_out_valid;
    assign o_res = r_out;

    always_comb begin
        n_state     = r_state;
        n_cap       = r_cap;
        n_cap_micro = r_cap_micro;
        n_rate      = r_rate;
        n_per_sec   = r_per_sec;
        n_level     = r_level;
        n_last      = r_last;
        n_job       = r_job;
        n_elapsed   = r_elapsed;
        n_prod_lo   = r_prod_lo;
        n_prod_hi   = r_prod_hi;
        n_prod      = r_prod;
        n_room      = r_room;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_q_pop     = 1'b0;

        if (i_cfg.we) begin
            case (i_cfg.idx)
                CFG_CAPACITY: begin
                    n_cap       = i_cfg.wdata[CAP_W-1:0];
                    n_cap_micro = cap_micro_w;
                    n_level     = cap_micro_w;
                end
                CFG_RATE: begin
                    n_rate    = i_cfg.wdata[RATE_W-1:0];
                    n_per_sec = per_sec_w;
                end
                default: ;
            endcase
        end

        if (pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty && !r_out_valid) begin
                    o_q_pop = 1'b1;
                    n_job   = i_q_job;
                    if (i_q_job.kind == JOB_FREE) begin
                        n_out.granted         = 1'b1;
                        n_out.retry_after_sec = '0;
                        n_out_valid           = 1'b1;
                    end else begin
                        n_last    = i_q_job.now_ms;
                        n_elapsed = i_q_job.now_ms - r_last;
                        if (i_q_job.now_ms > r_last && r_rate != '0) begin
                            n_state = S_MUL_LO;
                        end else begin
                            n_state = S_CHECK;
                        end
                    end
                end
            end
            S_MUL_LO: begin
                n_prod_lo = PP_W'(r_elapsed[HALF_W-1:0]) * PP_W'(r_rate);
                n_state   = S_MUL_HI;
            end
            S_MUL_HI: begin
                n_prod_hi = PP_W'(r_elapsed[LEVEL_W-1:HALF_W]) * PP_W'(r_rate);
                n_room    = r_cap_micro - r_level;
                n_state   = S_SUM;
            end
            S_SUM: begin
                n_prod  = PROD_W'(r_prod_lo) + PROD_W'({r_prod_hi, {HALF_W{1'b0}}});
                n_state = S_REFILL;
            end
            S_REFILL: begin
                // product beyond the room left fills the bucket
                if (elapsed_big || r_prod > PROD_W'(r_room)) begin
                    n_level = r_cap_micro;
                end else begin
                    n_level = r_level + r_prod[LEVEL_W-1:0];
                end
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_level >= r_job.need_micro) begin
                    n_level               = r_level - r_job.need_micro;
                    n_out.granted         = 1'b1;
                    n_out.retry_after_sec = '0;
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end else if (r_cap < r_job.cost_tokens || r_rate == '0) begin
                    n_out.granted         = 1'b0;
                    n_out.retry_after_sec = RETRY_ONE;
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end else begin
                    n_quo   = r_job.need_micro - r_level;
                    n_rem   = '0;
                    n_cnt   = DIV_CNT_W'(LEVEL_W - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = rem_ge ? PSEC_W'(rem_sh - {1'b0, r_per_sec}) : rem_sh[PSEC_W-1:0];
                n_quo = {r_quo[LEVEL_W-2:0], rem_ge};
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_FIN: begin
                n_out.granted = 1'b0;
                if (|ceil_q[LEVEL_W:RETRY_W]) begin
                    n_out.retry_after_sec = RETRY_MAX;
                end else if (ceil_q == '0) begin
                    n_out.retry_after_sec = RETRY_ONE;
                end else begin
                    n_out.retry_after_sec = ceil_q[RETRY_W-1:0];
                end
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= '0;
            r_cap_micro <= '0;
            r_rate      <= '0;
            r_per_sec   <= '0;
            r_level     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_cap_micro <= n_cap_micro;
            r_rate      <= n_rate;
            r_per_sec   <= n_per_sec;
            r_level     <= n_level;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_elapsed <= n_elapsed;
        r_prod_lo <= n_prod_lo;
        r_prod_hi <= n_prod_hi;
        r_prod    <= n_prod;
        r_room    <= n_room;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
    end

endmodule

[rtl/token_bucket_limiter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_bucket_limiter_core
// single token bucket request admission with retry-after estimate
// ----------------------------------------------------------------------------
//  channel   handshake               word
//  -------   ---------------------   -------------------------------------
//  request   push / full             i_req : now_ms, cost_tokens
//  result    pop / empty             o_res : granted, retry_after_sec
//  config    i_cfg_we (no wait)      i_cfg_idx, i_cfg_wdata
//
//  zero-cost word: popped from the queue and granted without touching the bucket
//  metered word: queue pop, two partial products, sum, refill and check,
//  or only queue pop and check when nothing is refilled; a retry time adds
//  the one-bit-per-cycle restoring divider (36 steps plus rounding)
//  reset is synchronous, active low: empty bucket, capacity and rate zero
//  a two-word job queue keeps taking requests while a result waits on pop;
//  the back end starts its next job the cycle after the result is popped
// ----------------------------------------------------------------------------
module token_bucket_limiter_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request side
    input  logic                             push,
    input  tbl_pkg::t_req                    i_req,
    output logic                             full,
    // result side
    output logic                             empty,
    input  logic                             pop,
    output tbl_pkg::t_res                    o_res,
    // configuration writes
    input  logic                             i_cfg_we,
    input  logic [tbl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tbl_pkg::CFG_W-1:0]        i_cfg_wdata
);
    import tbl_pkg::*;

    // front to queue
    logic q_push;
    t_job q_in_job;
    logic q_full;

    // queue to back
    t_job q_out_job;
    logic q_empty;
    logic q_pop;

    t_cfg cfg;

    assign cfg.we    = i_cfg_we;
    assign cfg.idx   = i_cfg_idx;
    assign cfg.wdata = i_cfg_wdata;

    // classify the request and scale its cost
    tbl_front u_front (
        .push     (push),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_job    (q_in_job),
        .full     (full)
    );

    // decouples request acceptance from the slow back end
    tbl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_out_job),
        .o_empty (q_empty)
    );

    // bucket state, refill, admission and retry divider; owns the result register
    tbl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_job   (q_out_job),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .pop       (pop),
        .empty     (empty),
        .o_res     (o_res)
    );

endmodule

[rtl/tbl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbl_checker
// port-level checks of the token bucket limiter
// ----------------------------------------------------------------------------
module tbl_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          full,
    input logic          empty,
    input logic          pop,
    input tbl_pkg::t_res o_res
);
    import tbl_pkg::*;

    // no result waits and the request side is not full right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> (empty && !full))
        else $error("result waiting or input full right after reset");

    // a waiting result that is not taken stays put
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_res)))
        else $error("waiting result changed or vanished");

    // a granted word never carries a wait time
    a_grant_no_retry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.granted) |-> (o_res.retry_after_sec == '0))
        else $error("granted result with nonzero retry");

    // a denied word always asks for at least one second
    a_deny_retry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_res.granted) |-> (o_res.retry_after_sec != '0))
        else $error("denied result with zero retry");

endmodule

bind token_bucket_limiter_core tbl_checker u_tbl_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_res   (o_res)
);
